FILE: rtl/assert_macros.svh
// Assertion macros shared by the grid maze reachability modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check a property on every rising edge once reset is released
`define GMR_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("grid maze check failed");
// Check a property on every rising edge, reset included
`define GMR_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("grid maze check failed");
`else
`define GMR_ASSERT(lbl, clk, rst_n, prop)
`define GMR_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: rtl/gmr_pkg.sv
// Types, constants and command structs for the grid maze reachability block
package gmr_pkg;

	// Grid storage and field widths
	localparam int MAX_ROWS = 16;
	localparam int MAX_COLS = 16;
	localparam int ROW_W    = 4;
	localparam int COL_W    = 4;
	localparam int CNT_W    = 5;
	localparam int CELLS    = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W   = ROW_W + COL_W;
	localparam int DEPTH_W  = ADDR_W + 1;

	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [DEPTH_W-1:0] depth_t;
	typedef logic [CNT_W-1:0]   cnt_t;

	// Item operation codes
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_SOLVE = 1'b1;

	// Configuration register indexes
	typedef enum logic [0:0] {
		REG_ROW_COUNT = 1'b0,
		REG_COL_COUNT = 1'b1
	} reg_idx_t;

	// Neighbour directions in visiting order
	typedef enum logic [1:0] {
		DIR_EAST  = 2'd0,
		DIR_SOUTH = 2'd1,
		DIR_WEST  = 2'd2,
		DIR_NORTH = 2'd3
	} dir_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load_we;
		logic solve_init;
		logic clr;
		logic pop;
		logic rd_issue;
		dir_t rd_dir;
		logic eval;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic clr_last;
		logic stk_empty;
		logic at_end;
	} sts_t;

endpackage

FILE: rtl/gmr_dpath.sv
// Datapath: grid memory, visited bits, coordinate stack and neighbour checks
`include "assert_macros.svh"

module gmr_dpath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  gmr_pkg::cmd_t             cmd,
	output gmr_pkg::sts_t             sts,
	input  logic                      cfg_we,
	input  logic [0:0]                cfg_index,
	input  logic [gmr_pkg::CNT_W-1:0] cfg_wdata,
	input  logic [gmr_pkg::ROW_W-1:0] cell_row,
	input  logic [gmr_pkg::COL_W-1:0] cell_col,
	input  logic                      cell_open,
	input  logic [gmr_pkg::ROW_W-1:0] start_row,
	input  logic [gmr_pkg::COL_W-1:0] start_col,
	input  logic [gmr_pkg::ROW_W-1:0] end_row,
	input  logic [gmr_pkg::COL_W-1:0] end_col
);

	logic                      open_mem  [gmr_pkg::CELLS];
	logic                      visit_mem [gmr_pkg::CELLS];
	gmr_pkg::addr_t            stk_mem   [gmr_pkg::CELLS];
	gmr_pkg::depth_t           depth_q;
	gmr_pkg::depth_t           depth_dec;
	gmr_pkg::cnt_t             row_cnt_q;
	gmr_pkg::cnt_t             col_cnt_q;
	gmr_pkg::cnt_t             rows_eff;
	gmr_pkg::cnt_t             cols_eff;
	gmr_pkg::addr_t            clr_q;
	gmr_pkg::addr_t            stk_rd_q;
	gmr_pkg::addr_t            cur_q;
	gmr_pkg::addr_t            start_q;
	gmr_pkg::addr_t            end_q;
	gmr_pkg::addr_t            base;
	gmr_pkg::cnt_t             base_row;
	gmr_pkg::cnt_t             base_col;
	gmr_pkg::cnt_t             nbr_row;
	gmr_pkg::cnt_t             nbr_col;
	gmr_pkg::addr_t            nbr_addr;
	logic                      nbr_ok;
	gmr_pkg::addr_t            addr_s1;
	logic                      ok_s1;
	logic                      open_rd_s1;
	logic                      visit_rd_s1;
	logic                      push;

	// Clamp the configured size to the storage
	assign rows_eff = (row_cnt_q > gmr_pkg::cnt_t'(gmr_pkg::MAX_ROWS)) ?
		gmr_pkg::cnt_t'(gmr_pkg::MAX_ROWS) : row_cnt_q;
	assign cols_eff = (col_cnt_q > gmr_pkg::cnt_t'(gmr_pkg::MAX_COLS)) ?
		gmr_pkg::cnt_t'(gmr_pkg::MAX_COLS) : col_cnt_q;

	// East is issued straight after the pop, so take the cell from the stack read
	assign base = (cmd.rd_dir == gmr_pkg::DIR_EAST) ? stk_rd_q : cur_q;

	// Step to the neighbour; a step below zero wraps high and falls outside
	always_comb begin
		base_row = {1'b0, base[gmr_pkg::ADDR_W-1:gmr_pkg::COL_W]};
		base_col = {1'b0, base[gmr_pkg::COL_W-1:0]};
		nbr_row  = base_row;
		nbr_col  = base_col;
		unique case (cmd.rd_dir)
			gmr_pkg::DIR_EAST:  nbr_col = base_col + gmr_pkg::cnt_t'(1);
			gmr_pkg::DIR_SOUTH: nbr_row = base_row + gmr_pkg::cnt_t'(1);
			gmr_pkg::DIR_WEST:  nbr_col = base_col - gmr_pkg::cnt_t'(1);
			gmr_pkg::DIR_NORTH: nbr_row = base_row - gmr_pkg::cnt_t'(1);
			default: begin
				nbr_row = base_row;
				nbr_col = base_col;
			end
		endcase
		nbr_ok   = (nbr_row < rows_eff) && (nbr_col < cols_eff);
		nbr_addr = {nbr_row[gmr_pkg::ROW_W-1:0], nbr_col[gmr_pkg::COL_W-1:0]};
	end

	assign depth_dec = depth_q - gmr_pkg::depth_t'(1);
	assign push      = cmd.eval && ok_s1 && open_rd_s1 && !visit_rd_s1;

	assign sts.stk_empty = (depth_q == '0);
	assign sts.at_end    = (stk_rd_q == end_q);
	assign sts.clr_last  = (clr_q == gmr_pkg::addr_t'(gmr_pkg::CELLS - 1));

	// Hold size registers, stack fill and the clearing pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_cnt_q <= gmr_pkg::cnt_t'(gmr_pkg::MAX_ROWS);
			col_cnt_q <= gmr_pkg::cnt_t'(gmr_pkg::MAX_COLS);
			depth_q   <= '0;
			clr_q     <= '0;
		end else begin
			if (cfg_we) begin
				unique case (gmr_pkg::reg_idx_t'(cfg_index))
					gmr_pkg::REG_ROW_COUNT: row_cnt_q <= cfg_wdata;
					gmr_pkg::REG_COL_COUNT: col_cnt_q <= cfg_wdata;
					default: row_cnt_q <= row_cnt_q;
				endcase
			end
			if (cmd.solve_init) begin
				depth_q <= gmr_pkg::depth_t'(1);
			end else if (cmd.pop) begin
				depth_q <= depth_dec;
			end else if (push) begin
				depth_q <= depth_q + gmr_pkg::depth_t'(1);
			end
			if (cmd.solve_init)
				clr_q <= '0;
			else if (cmd.clr)
				clr_q <= clr_q + gmr_pkg::addr_t'(1);
		end
	end

	// Write loaded cells, read the grid for the neighbour in flight
	always_ff @(posedge clk) begin
		if (cmd.load_we)
			open_mem[{cell_row, cell_col}] <= cell_open;
		if (cmd.rd_issue) begin
			open_rd_s1 <= open_mem[nbr_addr];
			addr_s1    <= nbr_addr;
			ok_s1      <= nbr_ok;
		end
	end

	// Clear the visited bits one a cycle, marking only the start, then mark pushed cells
	always_ff @(posedge clk) begin
		if (cmd.clr)
			visit_mem[clr_q] <= (clr_q == start_q);
		else if (push)
			visit_mem[addr_s1] <= 1'b1;
		if (cmd.rd_issue)
			visit_rd_s1 <= visit_mem[nbr_addr];
	end

	// Push and pop coordinates
	always_ff @(posedge clk) begin
		if (cmd.solve_init)
			stk_mem[0] <= {start_row, start_col};
		else if (push)
			stk_mem[depth_q[gmr_pkg::ADDR_W-1:0]] <= addr_s1;
		if (cmd.pop)
			stk_rd_q <= stk_mem[depth_dec[gmr_pkg::ADDR_W-1:0]];
	end

	// Latch the start, the target and the popped cell
	always_ff @(posedge clk) begin
		if (cmd.solve_init) begin
			start_q <= {start_row, start_col};
			end_q   <= {end_row, end_col};
		end
		if (cmd.rd_issue && (cmd.rd_dir == gmr_pkg::DIR_EAST))
			cur_q <= stk_rd_q;
	end

	`GMR_ASSERT(a_depth_bound, clk, arst_n, depth_q <= gmr_pkg::depth_t'(gmr_pkg::CELLS))
	`GMR_ASSERT(a_push_room, clk, arst_n, push |-> (depth_q < gmr_pkg::depth_t'(gmr_pkg::CELLS)))
	`GMR_ASSERT(a_init_one, clk, arst_n, cmd.solve_init |=> (depth_q == gmr_pkg::depth_t'(1)))

endmodule

FILE: rtl/gmr_ctrl.sv
// Controller: sequences loads, search steps and the result register
`include "assert_macros.svh"

module gmr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          operation,
	output logic          out_valid,
	input  logic          out_stall,
	output logic          path_found,
	output gmr_pkg::cmd_t cmd,
	input  gmr_pkg::sts_t sts
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_POP,
		ST_CHECK,
		ST_EVAL,
		ST_DONE
	} state_t;

	state_t       state_q;
	gmr_pkg::dir_t nbr_q;
	logic         found_q;
	logic         out_valid_q;
	logic         path_found_q;
	logic         in_acc;

	assign in_stall   = (state_q != ST_IDLE);
	assign in_acc     = in_valid && !in_stall;
	assign out_valid  = out_valid_q;
	assign path_found = path_found_q;

	// Decode commands for the datapath
	always_comb begin
		cmd            = '0;
		cmd.rd_dir     = gmr_pkg::DIR_EAST;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load_we    = in_acc && (operation == gmr_pkg::OP_LOAD);
				cmd.solve_init = in_acc && (operation == gmr_pkg::OP_SOLVE);
			end
			ST_CLEAR: cmd.clr = 1'b1;
			ST_POP:   cmd.pop = !sts.stk_empty;
			ST_CHECK: cmd.rd_issue = !sts.at_end;
			ST_EVAL: begin
				cmd.eval     = 1'b1;
				cmd.rd_issue = (nbr_q != gmr_pkg::DIR_NORTH);
				cmd.rd_dir   = gmr_pkg::dir_t'(nbr_q + 2'd1);
			end
			ST_DONE: cmd = '0;
			default: cmd = '0;
		endcase
	end

	// Advance the search and hold the result item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			nbr_q        <= gmr_pkg::DIR_EAST;
			found_q      <= 1'b0;
			out_valid_q  <= 1'b0;
			path_found_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && (operation == gmr_pkg::OP_SOLVE))
						state_q <= ST_CLEAR;
				end
				ST_CLEAR: begin
					if (sts.clr_last)
						state_q <= ST_POP;
				end
				ST_POP: begin
					if (sts.stk_empty) begin
						found_q <= 1'b0;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (sts.at_end) begin
						found_q <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						nbr_q   <= gmr_pkg::DIR_EAST;
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (nbr_q == gmr_pkg::DIR_NORTH) begin
						state_q <= ST_POP;
					end else begin
						nbr_q <= gmr_pkg::dir_t'(nbr_q + 2'd1);
					end
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q  <= 1'b1;
						path_found_q <= found_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`GMR_ASSERT(a_out_from_done, clk, arst_n, $rose(out_valid_q) |-> $past(state_q == ST_DONE))
	`GMR_ASSERT(a_pop_nonempty, clk, arst_n, cmd.pop |-> !sts.stk_empty)
	`GMR_ASSERT(a_eval_after_read, clk, arst_n, (state_q == ST_EVAL) |-> $past(cmd.rd_issue))

endmodule

FILE: rtl/grid_maze_reachability.sv
// Top level of the grid maze reachability block
//
// Input channel (in_valid / in_stall) carries one item: a load writes one
// cell of a 16 by 16 grid as open or wall, a solve asks whether end_row/col
// can be reached from start_row/col by orthogonal moves over open cells.
// The output channel (out_valid / out_stall) carries one path_found item per
// solve and none per load. Rows and columns in use are set through the
// cfg_we / cfg_index / cfg_wdata port, only while the block is idle: the
// user must keep to this; the block itself does not enforce it. Cells
// outside those rows and columns count as walls. A load does not leave
// the idle state, so in_stall stays low and a new item can follow it.
// A solve first clears the visited bits, one a cycle over all 256 cells,
// then for each popped cell runs a pop step, a target compare and four
// neighbour steps, one per grid read. The search ends when the target is
// popped or the coordinate stack runs empty (at most 256 cells popped).
// While a solve runs, in_stall stays high. A result waiting under
// out_stall holds the output register; a following load still goes ahead,
// and a following solve waits at its end until the register is free.
// Reset clears the stack fill and output and sets both sizes to 16;
// the grid contents are undefined until loaded.

module grid_maze_reachability (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [0:0]                cfg_index,
	input  logic [gmr_pkg::CNT_W-1:0] cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      operation,
	input  logic [gmr_pkg::ROW_W-1:0] cell_row,
	input  logic [gmr_pkg::COL_W-1:0] cell_col,
	input  logic                      cell_open,
	input  logic [gmr_pkg::ROW_W-1:0] start_row,
	input  logic [gmr_pkg::COL_W-1:0] start_col,
	input  logic [gmr_pkg::ROW_W-1:0] end_row,
	input  logic [gmr_pkg::COL_W-1:0] end_col,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      path_found
);

	gmr_pkg::cmd_t cmd;
	gmr_pkg::sts_t sts;

	// Sequence items and own the result register
	gmr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.path_found (path_found),
		.cmd        (cmd),
		.sts        (sts)
	);

	// Grid, visited bits and stack
	gmr_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cell_row  (cell_row),
		.cell_col  (cell_col),
		.cell_open (cell_open),
		.start_row (start_row),
		.start_col (start_col),
		.end_row   (end_row),
		.end_col   (end_col)
	);

endmodule
